### rtl/ffha_pkg.sv
// ffha_pkg: shared types and constants for the first-fit heap allocator
// no dependencies
package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int AW = $clog2(HEAP_BYTES);   // header store index width
  localparam int SW = AW + 1;               // size / break width
  localparam int HW = SW + 1;               // header word: size and used flag

  typedef logic [HW-1:0] hdr_t;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_EVAL,
    ST_F_RD,
    ST_F_EVAL,
    ST_M_RDC,
    ST_M_RDN,
    ST_M_EVAL,
    ST_M_FETCH,
    ST_DONE
  } state_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    hdr_t          wdata;
  } mem_req_t;

  function automatic logic [SW-1:0] hsize(input hdr_t h);
    return h[HW-1:1];
  endfunction

endpackage

### rtl/ffha_if.sv
// ffha_if: valid/ready channel interfaces for requests and results
// depends on ffha_pkg
interface ffha_req_if;
  import ffha_pkg::*;
  logic          valid;
  logic          ready;
  logic          kind;
  logic [12:0]   req_size;
  logic [11:0]   block_addr;
  modport source (output valid, kind, req_size, block_addr, input ready);
  modport sink   (input valid, kind, req_size, block_addr, output ready);
endinterface

interface ffha_rsp_if;
  logic          valid;
  logic          ready;
  logic [12:0]   payload_addr;
  logic          ok;
  modport source (output valid, payload_addr, ok, input ready);
  modport sink   (input valid, payload_addr, ok, output ready);
endinterface

### rtl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: top level, first-fit allocator over a header list
// depends on ffha_pkg, ffha_if, ffha_seq
//
//   channel  dir  handshake        payload
//   in_      in   valid / ready    kind, req_size, block_addr
//   out_     out  valid / ready    payload_addr, ok
//
// one transaction at a time: each header walked takes a read and an
// evaluation, and the merge pass reads each header and writes each merge;
// the single-port header memory sets the pace. synchronous active-low reset
// clears the break. the result waits in its register until taken;
// in_ready is low meanwhile.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ffha_req_if.sink   in_ch,
  ffha_rsp_if.source out_ch
);

  logic busy, done;

  ffha_seq u_seq (
    .clk(clk), .rst_n(rst_n),
    .start(in_ch.valid && !busy),
    .kind(in_ch.kind), .req_size(in_ch.req_size), .block_addr(in_ch.block_addr),
    .busy(busy), .done(done),
    .res_addr(out_ch.payload_addr), .res_ok(out_ch.ok),
    .res_taken(out_ch.ready)
  );

  assign in_ch.ready  = !busy;
  assign out_ch.valid = done;

endmodule

### rtl/ffha_hdr_mem.sv
// ffha_hdr_mem: header store, one write or one read per cycle, registered read
// depends on ffha_pkg
module ffha_hdr_mem
  import ffha_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output hdr_t     rdata
);

  hdr_t mem [HEAP_BYTES];

  // single port access
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

### rtl/ffha_seq.sv
// ffha_seq: sequencer that walks the header list, sharing a header-to-next adder
// depends on ffha_pkg, ffha_hdr_mem
module ffha_seq
  import ffha_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          kind,
  input  logic [12:0]   req_size,
  input  logic [11:0]   block_addr,
  output logic          busy,
  output logic          done,
  output logic [12:0]   res_addr,
  output logic          res_ok,
  input  logic          res_taken
);

  state_t        state_r, state_nxt;
  logic [SW-1:0] brk_r, brk_nxt;
  logic [SW-1:0] cur_r, cur_nxt;       // walk pointer / merge cur
  logic [SW-1:0] nxt_r, nxt_nxt;       // merge next pointer
  logic [SW-1:0] req_r, req_nxt;
  logic [SW-1:0] tgt_r, tgt_nxt;
  hdr_t          ch_r, ch_nxt;         // merge current header
  logic [12:0]   addr_r, addr_nxt;
  logic          ok_r, ok_nxt;
  mem_req_t      mreq;
  hdr_t          rdata;

  ffha_hdr_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

  // shared unit: header-to-next adder
  logic [SW-1:0] sz_rd;
  logic [SW:0]   next_rd;
  logic [SW:0]   room;
  logic [SW:0]   merged;
  assign sz_rd   = hsize(rdata);
  assign next_rd = {1'b0, cur_r} + (SW+1)'(HEADER_BYTES) + {1'b0, sz_rd};
  assign room    = (SW+1)'(HEAP_BYTES) - {1'b0, brk_r};
  assign merged  = {1'b0, hsize(ch_r)} + {1'b0, sz_rd} + (SW+1)'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      brk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      brk_r   <= brk_nxt;
    end
    cur_r  <= cur_nxt;
    nxt_r  <= nxt_nxt;
    req_r  <= req_nxt;
    tgt_r  <= tgt_nxt;
    ch_r   <= ch_nxt;
    addr_r <= addr_nxt;
    ok_r   <= ok_nxt;
  end

  // next state and memory control
  always_comb begin
    state_nxt = state_r;
    brk_nxt   = brk_r;
    cur_nxt   = cur_r;
    nxt_nxt   = nxt_r;
    req_nxt   = req_r;
    tgt_nxt   = tgt_r;
    ch_nxt    = ch_r;
    addr_nxt  = addr_r;
    ok_nxt    = ok_r;
    mreq.we    = 1'b0;
    mreq.addr  = cur_r[AW-1:0];
    mreq.wdata = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cur_nxt  = '0;
          req_nxt  = SW'(req_size);
          addr_nxt = '0;
          ok_nxt   = 1'b0;
          if (kind == KIND_ALLOC) begin
            state_nxt = ST_A_RD;
          end else if (block_addr < 12'(HEADER_BYTES)) begin
            state_nxt = ST_DONE;
          end else begin
            tgt_nxt   = SW'(block_addr) - SW'(HEADER_BYTES);
            state_nxt = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        if (cur_r < brk_r) begin
          state_nxt = ST_A_EVAL;
        end else if (room < (SW+1)'(HEADER_BYTES) ||
                     room - (SW+1)'(HEADER_BYTES) < {1'b0, req_r}) begin
          state_nxt = ST_DONE;
        end else begin
          // append at the break
          mreq.we    = 1'b1;
          mreq.addr  = brk_r[AW-1:0];
          mreq.wdata = {req_r, 1'b1};
          addr_nxt   = 13'(brk_r + SW'(HEADER_BYTES));
          ok_nxt     = 1'b1;
          brk_nxt    = brk_r + SW'(HEADER_BYTES) + req_r;
          state_nxt  = ST_DONE;
        end
      end
      ST_A_EVAL: begin
        if (!rdata[0] && sz_rd >= req_r) begin
          addr_nxt = 13'(cur_r + SW'(HEADER_BYTES));
          ok_nxt   = 1'b1;
          mreq.we  = 1'b1;
          if (sz_rd - req_r < SW'(HEADER_BYTES)) begin
            mreq.wdata = {sz_rd, 1'b1};
            state_nxt  = ST_DONE;
          end else begin
            // split: write front now, remainder header next cycle
            mreq.wdata = {req_r, 1'b1};
            nxt_nxt    = cur_r + SW'(HEADER_BYTES) + req_r;
            ch_nxt     = {sz_rd - req_r - SW'(HEADER_BYTES), 1'b0};
            state_nxt  = ST_M_RDN;
          end
        end else begin
          cur_nxt   = SW'(next_rd);
          state_nxt = ST_A_RD;
        end
      end
      ST_F_RD: begin
        if (cur_r < brk_r && cur_r <= tgt_r) begin
          state_nxt = ST_F_EVAL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_F_EVAL: begin
        if (cur_r == tgt_r) begin
          mreq.we    = 1'b1;
          mreq.wdata = {sz_rd, 1'b0};
          ok_nxt     = 1'b1;
          cur_nxt    = '0;
          state_nxt  = ST_M_RDC;
        end else begin
          cur_nxt   = SW'(next_rd);
          state_nxt = ST_F_RD;
        end
      end
      ST_M_RDC: begin
        // read cur header, issued; data next cycle
        mreq.addr = cur_r[AW-1:0];
        state_nxt = ST_M_RDN;
        nxt_nxt   = '0;
        ch_nxt    = '0;
        tgt_nxt   = '1;  // marks "cur header pending"
      end
      ST_M_RDN: begin
        if (tgt_r == '1 && ok_r && addr_r == '0) begin
          // merge pass: cur header arrives now
          ch_nxt  = rdata;
          nxt_nxt = SW'(next_rd);
          tgt_nxt = '0;
          mreq.addr = nxt_nxt[AW-1:0];
          if (SW'(next_rd) < brk_r) begin
            state_nxt = ST_M_EVAL;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          // split remainder write
          mreq.we    = 1'b1;
          mreq.addr  = nxt_r[AW-1:0];
          mreq.wdata = ch_r;
          state_nxt  = ST_DONE;
        end
      end
      ST_M_EVAL: begin
        // rdata holds header at nxt_r
        if (!ch_r[0] && !rdata[0]) begin
          ch_nxt     = {SW'(merged), 1'b0};
          mreq.we    = 1'b1;
          mreq.addr  = cur_r[AW-1:0];
          mreq.wdata = {SW'(merged), 1'b0};
          nxt_nxt    = SW'(merged) + cur_r + SW'(HEADER_BYTES);
        end else begin
          cur_nxt = nxt_r;
          ch_nxt  = rdata;
          nxt_nxt = nxt_r + SW'(HEADER_BYTES) + sz_rd;
        end
        if (nxt_nxt < brk_r) begin
          // the port is taken by a merge write, so the fetch moves to ST_M_FETCH
          if (mreq.we) begin
            state_nxt = ST_M_FETCH;
          end else begin
            mreq.addr = nxt_nxt[AW-1:0];
            state_nxt = ST_M_EVAL;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_M_FETCH: begin
        // read the header after the merged block
        mreq.addr = nxt_r[AW-1:0];
        state_nxt = ST_M_EVAL;
      end
      ST_DONE: begin
        if (res_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign done     = (state_r == ST_DONE);
  assign res_addr = addr_r;
  assign res_ok   = ok_r;

endmodule
